>>> rtl/dhcp_lease_pool_allocator_macros.svh
// Assertion macros for the DHCP lease pool allocator.
// Used by the RTL files that carry concurrent checks; expects clk and rst in scope.
`ifndef DHCP_LEASE_POOL_ALLOCATOR_MACROS_SVH
`define DHCP_LEASE_POOL_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define DLPA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dlpa assertion failed");
// Property checked on every clock edge, reset included.
`define DLPA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dlpa assertion failed");
`else
`define DLPA_ASSERT(label, prop)
`define DLPA_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> rtl/dlpa_pkg.sv
// Shared constants, codes and types for the DHCP lease pool allocator.
// No dependencies; imported by every RTL module of the block except dlpa_alu.
package dlpa_pkg;

  localparam int POOL_SIZE = 256;
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int Q_DEPTH   = 512;
  localparam int QA_W      = 9;
  localparam int QF_W      = 10;

  localparam logic [31:0] LEASE_SECONDS = 32'd60;

  // Message types.
  localparam logic [1:0] OP_DISCOVER = 2'd0;
  localparam logic [1:0] OP_REQUEST  = 2'd1;
  localparam logic [1:0] OP_RELEASE  = 2'd2;

  // Reply kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_OFFER = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_NAK   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SERVER_IP  = 2'd0;
  localparam logic [1:0] CFG_POOL_START = 2'd1;
  localparam logic [1:0] CFG_POOL_COUNT = 2'd2;

  // Write and read commands for the lease store.
  typedef struct packed {
    logic             we_mac;
    logic             we_end;
    logic [IDX_W-1:0] waddr;
    logic [47:0]      mac;
    logic [31:0]      end_time;
    logic [IDX_W-1:0] raddr;
  } store_cmd_t;

  // Write and read commands for the free index queue.
  typedef struct packed {
    logic             we;
    logic [QA_W-1:0]  waddr;
    logic [IDX_W-1:0] wdata;
    logic [QA_W-1:0]  raddr;
  } queue_cmd_t;

endpackage

>>> rtl/dhcp_lease_pool_allocator.sv
// DHCP lease pool allocator top level: sequencer, lease valid bits and queue pointers.
// Depends on dlpa_pkg, dlpa_alu, dlpa_store, dlpa_queue and the assertion macro header.

// One parsed DHCP message is taken at a time and answered with exactly one result
// (no reply, offer, ack or nak plus the address); no new message is taken until
// that result is loaded into the output register. The MAC lookup walks the pool
// entries, up to min(pool_count, 256) of them, through the single read port of
// the lease store, one entry a cycle, and stops at the first match. An init-reboot
// request whose address matches also reads the lease end time in S_END_RD and
// S_END_CHK. Each free-queue pop passes through S_POP_RD and S_POP_CHK; a discover
// or a no-address request that meets stale queue entries drops each one and pops
// the next. A result still waiting for out_ready holds the next message in S_OUT.
// Address, offset and end-time arithmetic all go through one shared 32-bit adder.
// After a write to pool_start or pool_count the free queue is reloaded by a sweep
// in S_CLEAR, during which no message is accepted. The user writes configuration
// only while no message is in flight; the block itself does not enforce this.
`include "dhcp_lease_pool_allocator_macros.svh"

module dhcp_lease_pool_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [47:0] client_mac,
  input  logic [31:0] req_addr,
  input  logic [31:0] server_ident,
  input  logic [31:0] client_ip,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  reply_kind,
  output logic [31:0] assigned_ip
);
  import dlpa_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_OFFS    = 4'd2;
  localparam logic [3:0] S_TIME    = 4'd3;
  localparam logic [3:0] S_SRCH    = 4'd4;
  localparam logic [3:0] S_DISP    = 4'd5;
  localparam logic [3:0] S_POP_RD  = 4'd6;
  localparam logic [3:0] S_POP_CHK = 4'd7;
  localparam logic [3:0] S_ADDR    = 4'd8;
  localparam logic [3:0] S_END_RD  = 4'd9;
  localparam logic [3:0] S_END_CHK = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  localparam logic [1:0] CHK_NONE   = 2'd0;
  localparam logic [1:0] CHK_SEL    = 2'd1;
  localparam logic [1:0] CHK_REBOOT = 2'd2;

  logic [3:0]           state;
  logic [31:0]          server_ip;
  logic [31:0]          pool_start;
  logic [CNT_W-1:0]     pool_count;
  logic [CNT_W-1:0]     n_act;
  logic [POOL_SIZE-1:0] leased;
  logic [CNT_W-1:0]     cnt;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic [QA_W-1:0]      queue_head;
  logic [QF_W-1:0]      queue_fill;

  logic [1:0]  op_r;
  logic [47:0] mac_r;
  logic [31:0] req_r;
  logic [31:0] sid_r;
  logic [31:0] cip_r;
  logic [31:0] now_r;
  logic [31:0] off_r;
  logic [31:0] endn_r;
  logic        found;
  logic [IDX_W-1:0] lease_idx;
  logic [IDX_W-1:0] idx_r;
  logic [1:0]  chk_r;
  logic [1:0]  kind_r;
  logic [31:0] res_addr;

  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_sub;
  logic [31:0] alu_y;
  logic        alu_carry;

  store_cmd_t       st_cmd;
  queue_cmd_t       q_cmd;
  logic [47:0]      mac_rd;
  logic [31:0]      end_rd;
  logic [IDX_W-1:0] q_rd;

  logic             off_ok;
  logic [IDX_W-1:0] off_idx;
  logic             rq_noaddr;
  logic             rq_sel;
  logic             rq_reboot;
  logic             rq_renew;
  logic             disp_grant_req;
  logic             disp_renew;
  logic             disp_release;
  logic             push_en;
  logic             pop_grant;
  logic             grant_en;
  logic [IDX_W-1:0] grant_idx;
  logic             reload;
  logic [CNT_W-1:0] cfg_n;

  assign in_ready = (state == S_IDLE);

  // Pool entries in use: pool_count clamped to the pool size.
  assign n_act = (pool_count > CNT_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : pool_count;
  assign cfg_n = (cfg_data[CNT_W-1:0] > CNT_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE)
                                                            : cfg_data[CNT_W-1:0];
  assign reload = cfg_we && ((cfg_index == CFG_POOL_START) || (cfg_index == CFG_POOL_COUNT));

  // Request branch decode, in priority order.
  assign rq_noaddr = (cip_r == '0) && (req_r == '0);
  assign rq_sel    = !rq_noaddr && (sid_r != '0) && (cip_r == '0);
  assign rq_reboot = !rq_noaddr && (sid_r == '0) && (cip_r == '0);
  assign rq_renew  = (cip_r != '0) && (sid_r == '0) && (req_r == '0);

  assign off_ok  = (off_r[31:CNT_W] == '0) && (off_r[CNT_W-1:0] < n_act);
  assign off_idx = off_r[IDX_W-1:0];

  // Store and queue side effects decided in the dispatch and pop states.
  assign disp_grant_req = (state == S_DISP) && (op_r == OP_DISCOVER) && !found &&
                          (req_r != '0) && off_ok && !leased[off_idx];
  assign disp_renew     = (state == S_DISP) && (op_r == OP_REQUEST) && rq_renew && found;
  assign disp_release   = (state == S_DISP) && (op_r == OP_RELEASE) &&
                          (sid_r == server_ip) && found;
  assign push_en        = disp_release && (queue_fill < QF_W'(Q_DEPTH));
  assign pop_grant      = (state == S_POP_CHK) && ({1'b0, q_rd} < n_act) && !leased[q_rd];
  assign grant_en       = disp_grant_req || pop_grant;
  assign grant_idx      = disp_grant_req ? off_idx : q_rd;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_OFFS: begin
        alu_a   = req_r;
        alu_b   = pool_start;
        alu_sub = 1'b1;
      end
      S_TIME: begin
        alu_a = now_r;
        alu_b = LEASE_SECONDS;
      end
      S_ADDR: begin
        alu_a = pool_start;
        alu_b = {{(32-IDX_W){1'b0}}, idx_r};
      end
      S_END_CHK: begin
        alu_a   = end_rd;
        alu_b   = now_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
      end
    endcase
  end

  dlpa_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .y     (alu_y),
    .carry (alu_carry)
  );

  // Lease store commands.
  always_comb begin
    st_cmd.we_mac   = grant_en;
    st_cmd.we_end   = grant_en || disp_renew;
    st_cmd.waddr    = disp_renew ? lease_idx : grant_idx;
    st_cmd.mac      = mac_r;
    st_cmd.end_time = endn_r;
    st_cmd.raddr    = (state == S_END_RD) ? idx_r : cnt[IDX_W-1:0];
  end

  dlpa_store u_store (
    .clk    (clk),
    .cmd    (st_cmd),
    .mac_rd (mac_rd),
    .end_rd (end_rd)
  );

  // Queue commands: the reload sweep or a push from a release.
  always_comb begin
    q_cmd.raddr = queue_head;
    if (state == S_CLEAR) begin
      q_cmd.we    = (cnt < n_act);
      q_cmd.waddr = QA_W'(cnt);
      q_cmd.wdata = cnt[IDX_W-1:0];
    end else begin
      q_cmd.we    = push_en;
      q_cmd.waddr = queue_head + queue_fill[QA_W-1:0];
      q_cmd.wdata = lease_idx;
    end
  end

  dlpa_queue u_queue (
    .clk   (clk),
    .cmd   (q_cmd),
    .rdata (q_rd)
  );

  // Lease valid bits.
  always_ff @(posedge clk) begin
    if (rst || reload) begin
      leased <= '0;
    end else begin
      if (grant_en) begin
        leased[grant_idx] <= 1'b1;
      end
      if (disp_release) begin
        leased[lease_idx] <= 1'b0;
      end
    end
  end

  // Item registers; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= operation;
      mac_r <= client_mac;
      req_r <= req_addr;
      sid_r <= server_ident;
      cip_r <= client_ip;
      now_r <= now_seconds;
    end
    if (state == S_OFFS) begin
      off_r <= alu_y;
    end
    if (state == S_TIME) begin
      endn_r <= alu_y;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      server_ip  <= '0;
      pool_start <= '0;
      pool_count <= '0;
      queue_head <= '0;
      queue_fill <= '0;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        queue_fill <= queue_fill + 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_OFFS;
          end
        end
        S_CLEAR: begin
          if (cnt < n_act) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OFFS: begin
          state <= S_TIME;
        end
        S_TIME: begin
          cnt    <= '0;
          rd_vld <= 1'b0;
          found  <= 1'b0;
          state  <= S_SRCH;
        end
        S_SRCH: begin
          // One entry issued and one compared each cycle.
          if (rd_vld && leased[rd_idx] && (mac_rd == mac_r)) begin
            found     <= 1'b1;
            lease_idx <= rd_idx;
            rd_vld    <= 1'b0;
            state     <= S_DISP;
          end else if (cnt < n_act) begin
            rd_idx <= cnt[IDX_W-1:0];
            rd_vld <= 1'b1;
            cnt    <= cnt + 1'b1;
          end else if (!rd_vld) begin
            state <= S_DISP;
          end else begin
            rd_vld <= 1'b0;
          end
        end
        S_DISP: begin
          chk_r    <= CHK_NONE;
          kind_r   <= KIND_NONE;
          res_addr <= '0;
          state    <= S_OUT;
          unique case (op_r)
            OP_DISCOVER: begin
              kind_r <= KIND_OFFER;
              if (found) begin
                idx_r <= lease_idx;
                state <= S_ADDR;
              end else if (disp_grant_req) begin
                idx_r <= off_idx;
                state <= S_ADDR;
              end else begin
                state <= S_POP_RD;
              end
            end
            OP_REQUEST: begin
              idx_r <= lease_idx;
              priority if (rq_noaddr) begin
                kind_r <= KIND_ACK;
                state  <= found ? S_ADDR : S_POP_RD;
              end else if (rq_sel) begin
                chk_r <= CHK_SEL;
                if (found) begin
                  state <= S_ADDR;
                end
              end else if (rq_reboot) begin
                chk_r <= CHK_REBOOT;
                if (found) begin
                  state <= S_ADDR;
                end
              end else if (rq_renew) begin
                if (found) begin
                  kind_r <= KIND_ACK;
                  state  <= S_ADDR;
                end
              end else begin
                state <= S_OUT;
              end
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_POP_RD: begin
          if (queue_fill == '0) begin
            kind_r   <= KIND_NONE;
            res_addr <= '0;
            state    <= S_OUT;
          end else begin
            queue_head <= queue_head + 1'b1;
            queue_fill <= queue_fill - 1'b1;
            state      <= S_POP_CHK;
          end
        end
        S_POP_CHK: begin
          // A stale index is dropped and the next one popped.
          if (pop_grant) begin
            idx_r <= q_rd;
            state <= S_ADDR;
          end else begin
            state <= S_POP_RD;
          end
        end
        S_ADDR: begin
          unique case (chk_r)
            CHK_SEL: begin
              if (alu_y == req_r) begin
                kind_r   <= KIND_ACK;
                res_addr <= req_r;
              end
              state <= S_OUT;
            end
            CHK_REBOOT: begin
              state <= (alu_y == req_r) ? S_END_RD : S_OUT;
            end
            default: begin
              res_addr <= alu_y;
              state    <= S_OUT;
            end
          endcase
        end
        S_END_RD: begin
          state <= S_END_CHK;
        end
        S_END_CHK: begin
          // A lease whose end lies before now is refused.
          if (!alu_carry) begin
            kind_r <= KIND_NAK;
          end else begin
            kind_r   <= KIND_ACK;
            res_addr <= req_r;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            reply_kind  <= kind_r;
            assigned_ip <= res_addr;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Configuration writes; a pool change reloads the free queue.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SERVER_IP: begin
            server_ip <= cfg_data;
          end
          CFG_POOL_START: begin
            pool_start <= cfg_data;
            queue_head <= '0;
            queue_fill <= QF_W'(n_act);
            cnt        <= '0;
            state      <= S_CLEAR;
          end
          CFG_POOL_COUNT: begin
            pool_count <= cfg_data[CNT_W-1:0];
            queue_head <= '0;
            queue_fill <= QF_W'(cfg_n);
            cnt        <= '0;
            state      <= S_CLEAR;
          end
          default: begin
            server_ip <= server_ip;
          end
        endcase
      end
    end
  end

  `DLPA_ASSERT(a_fill_bound, queue_fill <= QF_W'(Q_DEPTH))
  `DLPA_ASSERT(a_accept_starts, (in_valid && in_ready && !cfg_we) |=> (state == S_OFFS))
  `DLPA_ASSERT(a_grant_marks, (grant_en && !cfg_we) |=> leased[$past(grant_idx)])
  `DLPA_ASSERT_ALWAYS(a_reload_clears, (reload || rst) |=> (leased == '0))

endmodule

>>> rtl/dlpa_alu.sv
// Shared 32-bit adder/subtractor used by the allocator sequencer.
// Depends on nothing but its operands; carry out is high when a >= b on subtract.
module dlpa_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] y,
  output logic        carry
);

  logic [32:0] sum;

  // One adder serves both add and subtract through an inverted operand.
  assign sum   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {32'd0, sub};
  assign y     = sum[31:0];
  assign carry = sum[32];

endmodule

>>> rtl/dlpa_store.sv
// Lease store: per-entry client MAC and lease end time memories.
// Depends on dlpa_pkg for widths and the store command struct.
module dlpa_store (
  input  logic                clk,
  input  dlpa_pkg::store_cmd_t cmd,
  output logic [47:0]         mac_rd,
  output logic [31:0]         end_rd
);
  import dlpa_pkg::*;

  logic [47:0] mac_mem [POOL_SIZE];
  logic [31:0] end_mem [POOL_SIZE];

  // Writes at one address, registered read at another.
  always_ff @(posedge clk) begin
    if (cmd.we_mac) begin
      mac_mem[cmd.waddr] <= cmd.mac;
    end
    if (cmd.we_end) begin
      end_mem[cmd.waddr] <= cmd.end_time;
    end
    mac_rd <= mac_mem[cmd.raddr];
    end_rd <= end_mem[cmd.raddr];
  end

endmodule

>>> rtl/dlpa_queue.sv
// Storage of the free index queue, one write and one registered read a cycle.
// Depends on dlpa_pkg for widths and the queue command struct.
module dlpa_queue (
  input  logic                      clk,
  input  dlpa_pkg::queue_cmd_t      cmd,
  output logic [dlpa_pkg::IDX_W-1:0] rdata
);
  import dlpa_pkg::*;

  logic [IDX_W-1:0] mem [Q_DEPTH];

  // Pointer arithmetic lives in the sequencer; this is the array only.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rdata <= mem[cmd.raddr];
  end

endmodule

>>> dv/dhcp_lease_pool_allocator_tb.sv
// Self-checking testbench for the DHCP lease pool allocator.
// Depends on dlpa_pkg and the dhcp_lease_pool_allocator RTL; needs no files or arguments.
`default_nettype none

module dhcp_lease_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dlpa_pkg::*;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 1400;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] ip;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SERVER_IP;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_DISCOVER;
  logic [47:0] client_mac = '0;
  logic [31:0] req_addr = '0;
  logic [31:0] server_ident = '0;
  logic [31:0] client_ip = '0;
  logic [31:0] now_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  reply_kind;
  logic [31:0] assigned_ip;

  dhcp_lease_pool_allocator dut (.*);

  always #6 clk = ~clk;

  // Shadow copy of the lease pool and the free index queue.
  logic [31:0] own_ip, base_ip;
  int          count_reg;
  bit          leased [POOL_SIZE];
  logic [47:0] holder [POOL_SIZE];
  logic [31:0] lease_end [POOL_SIZE];
  logic [7:0]  free_idx [Q_DEPTH];
  int          fq_head, fq_fill;

  reply_t      pending_replies [$];
  int          errors = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 18;
  int          recv_idle_pct = 18;
  logic [31:0] clock_now = 32'd1000;
  logic [47:0] mac_set [6];

  function automatic int pool_entries();
    return (count_reg > POOL_SIZE) ? POOL_SIZE : count_reg;
  endfunction

  function automatic void rebuild_pool();
    int n;
    n = pool_entries();
    for (int i = 0; i < POOL_SIZE; i++) leased[i] = 1'b0;
    fq_head = 0;
    fq_fill = 0;
    for (int i = 0; i < n && fq_fill < Q_DEPTH; i++) begin
      free_idx[fq_fill] = i[7:0];
      fq_fill++;
    end
  endfunction

  function automatic int lease_of(logic [47:0] mac);
    for (int i = 0; i < pool_entries(); i++)
      if (leased[i] && holder[i] == mac) return i;
    return -1;
  endfunction

  function automatic void take_entry(int idx, logic [47:0] mac, logic [31:0] now);
    leased[idx] = 1'b1;
    holder[idx] = mac;
    lease_end[idx] = now + LEASE_SECONDS;
  endfunction

  // Pops queued indices, skipping stale ones, until a free entry is found.
  function automatic int pop_free(logic [47:0] mac, logic [31:0] now);
    int idx;
    while (fq_fill > 0) begin
      idx = int'(free_idx[fq_head]);
      fq_head = (fq_head + 1) % Q_DEPTH;
      fq_fill--;
      if (idx < pool_entries() && !leased[idx]) begin
        take_entry(idx, mac, now);
        return idx;
      end
    end
    return -1;
  endfunction

  // Updates the shadow pool for one message and returns the reply it calls for.
  function automatic reply_t predict_reply(logic [1:0] op, logic [47:0] mac,
                                           logic [31:0] req, logic [31:0] sid,
                                           logic [31:0] cip, logic [31:0] now);
    reply_t r;
    int lease;
    logic [31:0] off;
    r.kind = KIND_NONE;
    r.ip = '0;
    lease = lease_of(mac);
    case (op)
      OP_DISCOVER: begin
        if (lease < 0 && req != 0) begin
          off = req - base_ip;
          if (off < pool_entries() && !leased[off]) begin
            take_entry(off, mac, now);
            lease = off;
          end
        end
        if (lease < 0) lease = pop_free(mac, now);
        if (lease >= 0) begin
          r.kind = KIND_OFFER;
          r.ip = base_ip + lease;
        end
      end
      OP_REQUEST: begin
        if (cip == 0 && req == 0) begin
          if (lease < 0) lease = pop_free(mac, now);
          if (lease >= 0) begin
            r.kind = KIND_ACK;
            r.ip = base_ip + lease;
          end
        end else if (sid != 0 && cip == 0) begin
          if (lease >= 0 && base_ip + lease == req) begin
            r.kind = KIND_ACK;
            r.ip = req;
          end
        end else if (sid == 0 && cip == 0) begin
          if (lease >= 0 && base_ip + lease == req) begin
            if (lease_end[lease] < now) begin
              r.kind = KIND_NAK;
            end else begin
              r.kind = KIND_ACK;
              r.ip = req;
            end
          end
        end else if (sid == 0 && req == 0) begin
          if (lease >= 0) begin
            lease_end[lease] = now + LEASE_SECONDS;
            r.kind = KIND_ACK;
            r.ip = base_ip + lease;
          end
        end
      end
      OP_RELEASE: begin
        if (sid == own_ip && lease >= 0) begin
          leased[lease] = 1'b0;
          if (fq_fill < Q_DEPTH) begin
            free_idx[(fq_head + fq_fill) % Q_DEPTH] = lease[7:0];
            fq_fill++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predicts at input acceptance, checks at output acceptance, and watches for hangs.
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        pending_replies.insert(pending_replies.size(),
                               predict_reply(operation, client_mac, req_addr,
                                             server_ident, client_ip, now_seconds));
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply: expected none, actual kind %0d ip %h",
                   $time, reply_kind, assigned_ip);
          errors++;
        end else begin
          want = pending_replies[0];
          pending_replies.delete(0);
          if (reply_kind !== want.kind) begin
            $display("%0t: reply_kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, reply_kind);
            errors++;
          end
          if (assigned_ip !== want.ip) begin
            $display("%0t: assigned_ip mismatch: expected %h, actual %h",
                     $time, want.ip, assigned_ip);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // The receiver stalls at random.
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Sends one message; returns on the falling edge after it is accepted.
  task automatic send_msg(logic [1:0] op, logic [47:0] mac, logic [31:0] req,
                          logic [31:0] sid, logic [31:0] cip, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    client_mac = mac;
    req_addr = req;
    server_ident = sid;
    client_ip = cip;
    now_seconds = now;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every reply is back so the block is idle.
  task automatic drain();
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      CFG_SERVER_IP: own_ip = value;
      CFG_POOL_START: begin
        base_ip = value;
        rebuild_pool();
      end
      default: begin
        count_reg = int'(value[8:0]);
        rebuild_pool();
      end
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [47:0] any_mac();
    return 48'({$urandom, $urandom});
  endfunction

  // With an empty pool nothing can be handed out.
  task automatic test_empty_pool();
    send_msg(OP_DISCOVER, 48'h1, 32'h0, 32'h0, 32'h0, 32'd5);
    send_msg(OP_REQUEST, 48'h1, 32'h0, 32'h0, 32'h0, 32'd5);
    send_msg(OP_RELEASE, 48'h1, 32'h0, 32'h0, 32'h0, 32'd5);
  endtask

  // Every operation and request branch on a small pool that wraps past the top address.
  task automatic test_directed();
    logic [47:0] ma, mb;
    ma = 48'hFFFF_FFFF_FFFF;
    mb = 48'h0;
    write_reg(CFG_SERVER_IP, 32'hC0A8_0001);
    write_reg(CFG_POOL_START, 32'hFFFF_FFFE);
    write_reg(CFG_POOL_COUNT, 32'd4);
    send_msg(OP_DISCOVER, ma, 32'h0000_0001, 32'h0, 32'h0, 32'd100);
    send_msg(OP_DISCOVER, ma, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'd100);
    send_msg(OP_DISCOVER, mb, 32'h0000_0001, 32'h0, 32'h0, 32'd100);
    send_msg(OP_DISCOVER, mb, 32'h0, 32'h0, 32'h0, 32'd100);
    send_msg(OP_REQUEST, ma, 32'h0000_0001, 32'hC0A8_0001, 32'h0, 32'd110);
    send_msg(OP_REQUEST, ma, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0, 32'd110);
    send_msg(OP_REQUEST, ma, 32'h0000_0001, 32'h0, 32'h0, 32'd160);
    send_msg(OP_REQUEST, ma, 32'h0000_0001, 32'h0, 32'h0, 32'd161);
    send_msg(OP_REQUEST, ma, 32'h0, 32'h0, 32'h0A00_0001, 32'hFFFF_FFF0);
    send_msg(OP_REQUEST, ma, 32'h0000_0001, 32'h0, 32'h0, 32'h0000_0020);
    send_msg(OP_REQUEST, ma, 32'h0000_0001, 32'h1, 32'h0A00_0001, 32'd5);
    send_msg(OP_REQUEST, mb, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
    send_msg(OP_REQUEST, 48'h5, 32'h0, 32'h0, 32'h0, 32'd5);
    send_msg(OP_REQUEST, 48'h6, 32'h0, 32'h0, 32'h0, 32'd5);
    send_msg(OP_DISCOVER, 48'h7, 32'h0, 32'h0, 32'h0, 32'd5);
    send_msg(OP_RELEASE, ma, 32'h0, 32'hC0A8_0002, 32'h0, 32'd5);
    send_msg(OP_RELEASE, ma, 32'h0, 32'hC0A8_0001, 32'h0, 32'd5);
    send_msg(OP_UNKNOWN, 48'h7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_msg(OP_DISCOVER, 48'h7, 32'h0, 32'h0, 32'h0, 32'd6);
    send_msg(OP_REQUEST, 48'h7, 32'h0000_0000, 32'h0, 32'h0, 32'd6);
  endtask

  // Starts from a full pool's queue and pushes duplicates until pushes are dropped.
  // The whole fill runs with no idling on either side.
  task automatic test_queue_overflow();
    write_reg(CFG_POOL_COUNT, 32'd256);
    write_reg(CFG_POOL_START, 32'h0A00_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 258; k++) begin
      send_msg(OP_DISCOVER, 48'h1000 + 48'(k), 32'h0A00_0000, 32'h0, 32'h0, 32'd50);
      send_msg(OP_RELEASE, 48'h1000 + 48'(k), 32'h0, own_ip, 32'h0, 32'd50);
    end
    send_idle_pct = 18;
    recv_idle_pct = 18;
    for (int k = 0; k < 3; k++)
      send_msg(OP_DISCOVER, 48'h9000 + 48'(k), 32'h0, 32'h0, 32'h0, 32'd60);
  endtask

  // A full pool of the largest size, then a pool of zero entries.
  task automatic test_pool_extremes();
    write_reg(CFG_POOL_START, 32'h0);
    write_reg(CFG_POOL_COUNT, 32'd256);
    write_reg(CFG_SERVER_IP, 32'hFFFF_FFFF);
    send_msg(OP_DISCOVER, 48'hAA, 32'd255, 32'h0, 32'h0, 32'd1);
    send_msg(OP_DISCOVER, 48'hAB, 32'd256, 32'h0, 32'h0, 32'd1);
    send_msg(OP_RELEASE, 48'hAA, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'd1);
    send_msg(OP_REQUEST, 48'hAB, 32'd0, 32'hFFFF_FFFF, 32'h0, 32'd1);
    write_reg(CFG_POOL_COUNT, 32'd0);
    send_msg(OP_DISCOVER, 48'hAB, 32'd0, 32'h0, 32'h0, 32'd1);
    write_reg(CFG_SERVER_IP, 32'h0);
  endtask

  // One random message, mostly from a small set of clients and pool addresses.
  task automatic send_random_msg();
    logic [1:0]  op;
    logic [47:0] mac;
    logic [31:0] req, sid, cip;
    int pick;
    pick = $urandom_range(99);
    op = (pick < 40) ? OP_DISCOVER : (pick < 80) ? OP_REQUEST :
         (pick < 95) ? OP_RELEASE : OP_UNKNOWN;
    mac = ($urandom_range(99) < 85) ? mac_set[$urandom_range(5)] : any_mac();
    pick = $urandom_range(9);
    req = (pick < 3) ? 32'h0 : (pick < 8) ? base_ip + $urandom_range(count_reg) : $urandom;
    pick = $urandom_range(9);
    sid = (pick < 4) ? 32'h0 : (pick < 8) ? own_ip : $urandom;
    cip = ($urandom_range(9) < 5) ? 32'h0 : $urandom;
    if (op == OP_REQUEST) begin
      // Bias toward the four well-formed request shapes.
      case ($urandom_range(5))
        0: begin req = 0; cip = 0; end
        1: begin cip = 0; if (sid == 0) sid = own_ip | 32'h1; end
        2: begin sid = 0; cip = 0; end
        3: begin sid = 0; req = 0; if (cip == 0) cip = 32'h0A00_0005; end
        default: ;
      endcase
    end
    if ($urandom_range(49) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(40);
    send_msg(op, mac, req, sid, cip, clock_now);
  endtask

  // Random phases, each under a fresh configuration.
  task automatic test_random_traffic();
    int cnt;
    for (int phase = 0; phase < 5; phase++) begin
      for (int i = 0; i < 6; i++) mac_set[i] = any_mac();
      cnt = (phase == 2) ? 256 : $urandom_range(1, 16);
      write_reg(CFG_SERVER_IP, ($urandom_range(3) == 0) ? 32'h0 : $urandom);
      write_reg(CFG_POOL_START, ($urandom_range(3) == 0) ? 32'hFFFF_FFF8 : $urandom);
      write_reg(CFG_POOL_COUNT, cnt);
      // One phase runs with no idling on either side.
      send_idle_pct = (phase == 1) ? 0 : 18;
      recv_idle_pct = (phase == 1) ? 0 : 18;
      for (int i = 0; i < ((cnt == 256) ? 8 : 13); i++) send_random_msg();
    end
    send_idle_pct = 18;
    recv_idle_pct = 18;
  endtask

  initial begin
    own_ip = '0;
    base_ip = '0;
    count_reg = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      holder[i] = '0;
      lease_end[i] = '0;
    end
    rebuild_pool();
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_empty_pool();
    test_directed();
    test_pool_extremes();
    test_queue_overflow();
    test_random_traffic();
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/dlpa_pkg.sv
rtl/dlpa_alu.sv
rtl/dlpa_store.sv
rtl/dlpa_queue.sv
rtl/dhcp_lease_pool_allocator.sv
dv/dhcp_lease_pool_allocator_tb.sv
